/* rtl/core/frd_pkg.sv */
// Shared types and constants for the frame rate decimator.
`default_nettype none
package frd_pkg;

  localparam int unsigned WINDOW_MS  = 60000;
  localparam int unsigned MS_PER_S   = 1000;
  localparam int unsigned RATIO_BIAS = 2;

  localparam int unsigned DVD_W = 42;
  localparam int unsigned DVS_W = 17;
  localparam int unsigned CNT_W = 6;
  localparam int unsigned SHORT_ITERS = DVS_W;
  localparam int unsigned LONG_ITERS  = DVD_W;

  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  localparam logic REG_EXPECTED_FPS = 1'b0;
  localparam logic REG_NO_SKIP      = 1'b1;

  localparam logic [1:0] CAUSE_PASS  = 2'd0;
  localparam logic [1:0] CAUSE_RATIO = 2'd1;
  localparam logic [1:0] CAUSE_QUOTA = 2'd2;

  typedef struct packed {
    logic [31:0] now_second;
    logic [31:0] now_ms;
  } frd_in_t;

  typedef struct packed {
    logic        accepted;
    logic [1:0]  drop_cause;
    logic [15:0] frame_index;
    logic [31:0] second_stamp;
    logic [15:0] fps_estimate;
    logic [31:0] skip_owed;
  } frd_out_t;

  typedef struct packed {
    logic [15:0] expected_fps;
    logic        no_skip;
  } frd_cfg_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
    logic [CNT_W-1:0] iters;
  } frd_div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
    logic [DVS_W-1:0] remainder;
  } frd_div_rsp_t;

endpackage
`default_nettype wire

/* rtl/core/frd_divider.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none
module frd_divider (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire frd_pkg::frd_div_req_t req,
  output frd_pkg::frd_div_rsp_t    rsp
);
  import frd_pkg::*;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVD_W-1:0] dvd_r, dvd_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W:0]   rem_sh;
  logic             ge;

  assign rem_sh = {rem_r, dvd_r[DVD_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = req.iters;
      dvd_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[DVD_W-2:0], ge};
      rem_nxt = ge ? DVS_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[DVS_W-1:0];
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = dvd_r;
  assign rsp.remainder = rem_r;

endmodule
`default_nettype wire

/* rtl/core/frd_cfg.sv */
// APB register bank: expected frame rate and decimation disable.
`default_nettype none
module frd_cfg (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [frd_pkg::APB_AW-1:0]  paddr,
  input  wire logic [frd_pkg::APB_DW-1:0]  pwdata,
  output logic      [frd_pkg::APB_DW-1:0]  prdata,
  output logic                             pready,
  output frd_pkg::frd_cfg_t                cfg
);
  import frd_pkg::*;

  logic [15:0] exp_fps_r, exp_fps_nxt;
  logic        no_skip_r, no_skip_nxt;
  logic        wr;
  logic        sel;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign sel    = paddr[2];

  always_comb begin
    exp_fps_nxt = exp_fps_r;
    no_skip_nxt = no_skip_r;
    if (wr) begin
      unique case (sel)
        REG_EXPECTED_FPS: exp_fps_nxt = pwdata[15:0];
        REG_NO_SKIP:      no_skip_nxt = pwdata[0];
        default:          exp_fps_nxt = exp_fps_r;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_EXPECTED_FPS: prdata = {16'd0, exp_fps_r};
      REG_NO_SKIP:      prdata = {31'd0, no_skip_r};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_fps_r <= 16'd30;
      no_skip_r <= 1'b0;
    end else begin
      exp_fps_r <= exp_fps_nxt;
      no_skip_r <= no_skip_nxt;
    end
  end

  assign cfg.expected_fps = exp_fps_r;
  assign cfg.no_skip      = no_skip_r;

endmodule
`default_nettype wire

/* rtl/core/frame_rate_decimator_top.sv */
// Frame rate decimator: per-second window, rate estimate, ratio and quota drops.
// The shared bit-serial divider takes 42 steps for the rate estimate, 17 for each ratio
// division and the index modulo; the estimate runs only in a new second, the ratio
// divisions only when a ratio drop may apply. One frame at a time: a new frame is held
// off until the result of the last one is loaded, which waits while the result stalls.
// Reset (synchronous, rst_n low) clears all counters and the window state.
`default_nettype none
module frame_rate_decimator_top (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire frd_pkg::frd_in_t            in_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output frd_pkg::frd_out_t                out_data,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [frd_pkg::APB_AW-1:0]  paddr,
  input  wire logic [frd_pkg::APB_DW-1:0]  pwdata,
  output logic      [frd_pkg::APB_DW-1:0]  prdata,
  output logic                             pready
);
  import frd_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE      = 13'b0000000000001,
    S_FOLD      = 13'b0000000000010,
    S_MUL       = 13'b0000000000100,
    S_FDIV_GO   = 13'b0000000001000,
    S_FDIV_WAIT = 13'b0000000010000,
    S_OWED      = 13'b0000000100000,
    S_RATIO     = 13'b0000001000000,
    S_K_WAIT    = 13'b0000010000000,
    S_CEIL_GO   = 13'b0000100000000,
    S_C_WAIT    = 13'b0001000000000,
    S_MOD_GO    = 13'b0010000000000,
    S_FINISH    = 13'b0100000000000,
    S_M_WAIT    = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;

  frd_cfg_t     cfg;
  frd_div_req_t div_req;
  frd_div_rsp_t div_rsp;

  logic [31:0]      sec_r, sec_nxt;
  logic [31:0]      ms_r, ms_nxt;
  logic [31:0]      cur_sec_r, cur_sec_nxt;
  logic [15:0]      fis_r, fis_nxt;
  logic [15:0]      pis_r, pis_nxt;
  logic [15:0]      rate_r, rate_nxt;
  logic [31:0]      wtot_r, wtot_nxt;
  logic [31:0]      wstart_r, wstart_nxt;
  logic [31:0]      owed_r, owed_nxt;
  logic [15:0]      dlt_r, dlt_nxt;
  logic [DVD_W-1:0] prod_r, prod_nxt;
  logic [DVS_W-1:0] k_r, k_nxt;
  logic             mode_ne_r, mode_ne_nxt;
  logic             rdrop_r, rdrop_nxt;
  logic             out_valid_r, out_valid_nxt;
  frd_out_t         out_data_r, out_data_nxt;

  logic [31:0]      diff_a, diff_b, span;
  logic [15:0]      ex;
  logic [15:0]      idx;
  logic [DVS_W-1:0] k_q;
  logic [DVS_W-1:0] k_ceil;
  logic [1:0]       cause;
  logic             can_load;

  frd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  frd_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign diff_a   = ms_r - wstart_r;
  assign diff_b   = wstart_r - ms_r;
  assign span     = diff_a[31] ? diff_b : diff_a;
  assign ex       = (cfg.expected_fps == 16'd0) ? 16'd1 : cfg.expected_fps;
  assign idx      = fis_r - 16'd1;
  assign k_q      = div_rsp.quotient[DVS_W-1:0];
  assign k_ceil   = k_q + DVS_W'(div_rsp.remainder != '0);
  assign can_load = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    if (rdrop_r) begin
      cause = CAUSE_RATIO;
    end else if (!cfg.no_skip && (pis_r >= ex)) begin
      cause = CAUSE_QUOTA;
    end else begin
      cause = CAUSE_PASS;
    end
  end

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = {1'b0, idx, 25'd0};
    div_req.divisor  = k_r;
    div_req.iters    = CNT_W'(SHORT_ITERS);
    unique case (state_r)
      S_FDIV_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = prod_r;
        div_req.divisor  = {1'b0, dlt_r};
        div_req.iters    = CNT_W'(LONG_ITERS);
      end
      S_RATIO: begin
        div_req.start    = !cfg.no_skip && (rate_r > ex);
        div_req.dividend = (ex > 16'(RATIO_BIAS))
                           ? {(17'(rate_r) + 17'(RATIO_BIAS)), 25'd0}
                           : {1'b0, rate_r, 25'd0};
        div_req.divisor  = {1'b0, ex};
      end
      S_CEIL_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = {1'b0, rate_r, 25'd0};
        div_req.divisor  = {1'b0, rate_r - ex};
      end
      S_MOD_GO: begin
        div_req.start    = 1'b1;
      end
      default: div_req.start = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    sec_nxt       = sec_r;
    ms_nxt        = ms_r;
    cur_sec_nxt   = cur_sec_r;
    fis_nxt       = fis_r;
    pis_nxt       = pis_r;
    rate_nxt      = rate_r;
    wtot_nxt      = wtot_r;
    wstart_nxt    = wstart_r;
    owed_nxt      = owed_r;
    dlt_nxt       = dlt_r;
    prod_nxt      = prod_r;
    k_nxt         = k_r;
    mode_ne_nxt   = mode_ne_r;
    rdrop_nxt     = rdrop_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          sec_nxt   = in_data.now_second;
          ms_nxt    = in_data.now_ms;
          rdrop_nxt = 1'b0;
          state_nxt = S_FOLD;
        end
      end
      S_FOLD: begin
        if (sec_r != cur_sec_r) begin
          fis_nxt     = 16'd1;
          pis_nxt     = 16'd0;
          cur_sec_nxt = sec_r;
          dlt_nxt     = span[15:0];
          if (span > 32'(WINDOW_MS)) begin
            wtot_nxt   = '0;
            wstart_nxt = ms_r;
            state_nxt  = S_OWED;
          end else if (span != 32'd0) begin
            wtot_nxt  = wtot_r + {16'd0, fis_r};
            state_nxt = S_MUL;
          end else begin
            state_nxt = S_OWED;
          end
        end else begin
          if (fis_r != 16'hFFFF) begin
            fis_nxt = fis_r + 16'd1;
          end
          state_nxt = S_RATIO;
        end
      end
      S_MUL: begin
        prod_nxt  = DVD_W'(wtot_r) * DVD_W'(MS_PER_S);
        state_nxt = S_FDIV_GO;
      end
      S_FDIV_GO: begin
        state_nxt = S_FDIV_WAIT;
      end
      S_FDIV_WAIT: begin
        if (div_rsp.done) begin
          rate_nxt  = (div_rsp.quotient[DVD_W-1:16] != '0) ? 16'hFFFF
                                                           : div_rsp.quotient[15:0];
          state_nxt = S_OWED;
        end
      end
      S_OWED: begin
        owed_nxt  = (rate_r > cfg.expected_fps) ? {16'd0, rate_r - cfg.expected_fps}
                                                : 32'd0;
        state_nxt = S_RATIO;
      end
      S_RATIO: begin
        state_nxt = div_req.start ? S_K_WAIT : S_FINISH;
      end
      S_K_WAIT: begin
        if (div_rsp.done) begin
          if (k_q > DVS_W'(1)) begin
            k_nxt       = k_q;
            mode_ne_nxt = 1'b1;
            state_nxt   = S_MOD_GO;
          end else begin
            mode_ne_nxt = 1'b0;
            state_nxt   = S_CEIL_GO;
          end
        end
      end
      S_CEIL_GO: begin
        state_nxt = S_C_WAIT;
      end
      S_C_WAIT: begin
        if (div_rsp.done) begin
          k_nxt     = k_ceil;
          state_nxt = S_MOD_GO;
        end
      end
      S_MOD_GO: begin
        state_nxt = S_M_WAIT;
      end
      S_M_WAIT: begin
        if (div_rsp.done) begin
          rdrop_nxt = mode_ne_r ? (div_rsp.remainder != '0) : (div_rsp.remainder == '0);
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (can_load) begin
          if (rdrop_r) begin
            owed_nxt = owed_r - 32'd1;
          end
          if ((cause == CAUSE_PASS) && (pis_r != 16'hFFFF)) begin
            pis_nxt = pis_r + 16'd1;
          end
          out_valid_nxt             = 1'b1;
          out_data_nxt.accepted     = (cause == CAUSE_PASS);
          out_data_nxt.drop_cause   = cause;
          out_data_nxt.frame_index  = idx;
          out_data_nxt.second_stamp = (cause == CAUSE_PASS) ? sec_r : 32'd0;
          out_data_nxt.fps_estimate = rate_r;
          out_data_nxt.skip_owed    = rdrop_r ? (owed_r - 32'd1) : owed_r;
          state_nxt                 = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_sec_r   <= '0;
      fis_r       <= '0;
      pis_r       <= '0;
      rate_r      <= '0;
      wtot_r      <= '0;
      wstart_r    <= '0;
      owed_r      <= '0;
      mode_ne_r   <= 1'b0;
      rdrop_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_sec_r   <= cur_sec_nxt;
      fis_r       <= fis_nxt;
      pis_r       <= pis_nxt;
      rate_r      <= rate_nxt;
      wtot_r      <= wtot_nxt;
      wstart_r    <= wstart_nxt;
      owed_r      <= owed_nxt;
      mode_ne_r   <= mode_ne_nxt;
      rdrop_r     <= rdrop_nxt;
      out_valid_r <= out_valid_nxt;
    end
    sec_r      <= sec_nxt;
    ms_r       <= ms_nxt;
    dlt_r      <= dlt_nxt;
    prod_r     <= prod_nxt;
    k_r        <= k_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

/* rtl/core/frd_checker.sv */
// Port-level checks on the result channel of the frame rate decimator.
`default_nettype none
module frd_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire frd_pkg::frd_out_t out_data
);
  import frd_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or vanished");

  a_accept_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.accepted == (out_data.drop_cause == CAUSE_PASS)))
    else $error("accepted flag disagrees with drop cause");

  a_drop_stamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.accepted |-> (out_data.second_stamp == 32'd0))
    else $error("dropped frame carries a second stamp");

  a_cause_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.drop_cause == CAUSE_PASS ||
                   out_data.drop_cause == CAUSE_RATIO ||
                   out_data.drop_cause == CAUSE_QUOTA))
    else $error("unknown drop cause");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind frame_rate_decimator_top frd_checker u_frd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for frame_rate_decimator_top: predicts every frame verdict and compares.
`timescale 1ns / 100ps
module testbench;
  import frd_pkg::*;

  localparam int unsigned QUIET_LIMIT = 20000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned MAX_REPORTS = 30;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  frd_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  frd_out_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;

  frame_rate_decimator_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  // predictor copy of registers and per-second state
  logic [15:0] cfg_expected = 16'd30;
  logic cfg_no_skip = 1'b0;
  logic [31:0] cur_sec = '0;
  logic [15:0] frames_sec = '0;
  logic [15:0] passed_sec = '0;
  logic [15:0] rate_est = '0;
  logic [31:0] win_total = '0;
  logic [31:0] win_start_ms = '0;
  logic [31:0] owed = '0;

  frd_out_t verdicts_due[$];

  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_asked = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned errors = 0;
  int unsigned n_frames = 0;
  int unsigned n_passed = 0;
  int unsigned n_ratio = 0;
  int unsigned n_quota = 0;
  int unsigned n_held = 0;
  int unsigned n_writes = 0;

  function automatic bit ratio_hit(logic [15:0] idx, logic [31:0] fin, logic [31:0] ex);
    logic [31:0] k;
    logic [31:0] d;
    if (fin <= ex) return 1'b0;
    k = (ex > RATIO_BIAS) ? (fin + RATIO_BIAS) / ex : fin / ex;
    if (k > 32'd1) return (idx % k) != 32'd0;
    d = fin - ex;
    k = fin / d;
    if (fin > d * k) k = k + 32'd1;
    return (idx % k) == 32'd0;
  endfunction

  function automatic frd_out_t decimate_frame(frd_in_t f);
    frd_out_t r;
    logic [31:0] gap;
    logic [31:0] ex;
    logic [63:0] q;
    logic [15:0] idx;
    logic [1:0] cause;
    if (f.now_second != cur_sec) begin
      gap = f.now_ms - win_start_ms;
      if (gap[31]) gap = 32'd0 - gap;
      if (gap > WINDOW_MS) begin
        win_total = 32'd0;
        win_start_ms = f.now_ms;
      end else if (gap != 32'd0) begin
        win_total = win_total + {16'd0, frames_sec};
        q = ({32'd0, win_total} * 64'd1000) / {32'd0, gap};
        rate_est = (q > 64'd65535) ? 16'hFFFF : q[15:0];
      end
      owed = (rate_est > cfg_expected) ? {16'd0, rate_est - cfg_expected} : 32'd0;
      frames_sec = 16'd1;
      passed_sec = 16'd0;
      cur_sec = f.now_second;
    end else if (frames_sec != 16'hFFFF) begin
      frames_sec = frames_sec + 16'd1;
    end
    idx = frames_sec - 16'd1;
    cause = CAUSE_PASS;
    if (!cfg_no_skip) begin
      ex = (cfg_expected == 16'd0) ? 32'd1 : {16'd0, cfg_expected};
      if (ratio_hit(idx, {16'd0, rate_est}, ex)) begin
        owed = owed - 32'd1;
        cause = CAUSE_RATIO;
      end else if ({16'd0, passed_sec} >= ex) begin
        cause = CAUSE_QUOTA;
      end
    end
    if (cause == CAUSE_PASS && passed_sec != 16'hFFFF) passed_sec = passed_sec + 16'd1;
    r.accepted = (cause == CAUSE_PASS);
    r.drop_cause = cause;
    r.frame_index = idx;
    r.second_stamp = (cause == CAUSE_PASS) ? f.now_second : 32'd0;
    r.fps_estimate = rate_est;
    r.skip_owed = owed;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t mismatch %s: expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : check_results
    frd_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (verdicts_due.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t mismatch result: expected none, actual %h", $time, out_data);
      end else begin
        want = verdicts_due.pop_front();
        check_field("accepted", 32'(want.accepted), 32'(out_data.accepted));
        check_field("drop_cause", 32'(want.drop_cause), 32'(out_data.drop_cause));
        check_field("frame_index", 32'(want.frame_index), 32'(out_data.frame_index));
        check_field("second_stamp", want.second_stamp, out_data.second_stamp);
        check_field("fps_estimate", 32'(want.fps_estimate), 32'(out_data.fps_estimate));
        check_field("skip_owed", want.skip_owed, out_data.skip_owed);
        case (out_data.drop_cause)
          CAUSE_PASS: n_passed++;
          CAUSE_RATIO: n_ratio++;
          CAUSE_QUOTA: n_quota++;
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_asked) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_served <= hold_served + 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (in_valid && in_stall) n_held <= n_held + 1;
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic settle();
    in_valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic reg_sel, input logic [15:0] value);
    logic [15:0] mask;
    mask = (reg_sel == REG_NO_SKIP) ? 16'h0001 : 16'hFFFF;
    settle();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_sel, 2'b00};
    pwdata <= {16'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (reg_sel == REG_NO_SKIP) cfg_no_skip = value[0];
    else cfg_expected = value;
    n_writes++;
    // read back through the same port
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    check_field("readback", {16'd0, value & mask}, {16'd0, prdata[15:0] & mask});
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_frame(input logic [31:0] sec, input logic [31:0] ms);
    frd_in_t f;
    f.now_second = sec;
    f.now_ms = ms;
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    in_valid <= 1'b1;
    in_data <= f;
    do @(posedge clk); while (in_stall);
    verdicts_due.push_back(decimate_frame(f));
    n_frames++;
  endtask

  // seconds of traffic with random frame counts and steered tick jumps
  task automatic run_stream(input int unsigned items, input int unsigned mean_fps);
    logic [31:0] sec;
    logic [31:0] ms;
    int unsigned per_sec;
    int unsigned step;
    int unsigned sent;
    sec = ($urandom_range(3) == 0) ? 32'hFFFFFFFF - $urandom_range(3) : $urandom();
    ms = $urandom();
    sent = 0;
    while (sent < items) begin
      sec = ($urandom_range(19) == 0) ? $urandom() : sec + 32'd1;
      case ($urandom_range(19))
        0: ms = win_start_ms;
        1: ms = win_start_ms + WINDOW_MS;
        2: ms = win_start_ms + WINDOW_MS + 32'd1;
        3: ms = win_start_ms - $urandom_range(3, 1);
        4: ms = $urandom();
        default: ms = ms + 32'd950 + $urandom_range(100);
      endcase
      per_sec = $urandom_range(2 * mean_fps, 1);
      step = 1000 / per_sec;
      for (int unsigned i = 0; i < per_sec && sent < items; i++) begin
        send_frame(sec, ms);
        ms = ms + step;
        sent++;
      end
    end
  endtask

  task automatic test_directed();
    gap_pct = 0;
    stall_pct = 0;
    send_frame(32'd0, 32'd0);
    send_frame(32'd0, 32'hFFFFFFFF);
    send_frame(32'd1, 32'd0);
    send_frame(32'd2, WINDOW_MS);
    send_frame(32'd3, 32'd120001);
    for (int unsigned i = 0; i < 7; i++) send_frame(32'd4, 32'd120006 + i);
    send_frame(32'd5, 32'd119999);
    send_frame(32'hFFFFFFFF, 32'hFFFFFFFF);
    send_frame(32'd0, 32'd4);
    send_frame(32'd0, 32'd5);
    send_frame(32'd0, 32'd6);
  endtask

  task automatic test_config_extremes();
    write_reg(REG_EXPECTED_FPS, 16'd0);
    for (int unsigned i = 0; i < 4; i++) send_frame(32'd1, 32'd1004 + i);
    write_reg(REG_EXPECTED_FPS, 16'd2);
    for (int unsigned i = 0; i < 4; i++) send_frame(32'd2, 32'd2004 + i);
    write_reg(REG_EXPECTED_FPS, 16'hFFFF);
    send_frame(32'd3, 32'd3004);
    send_frame(32'd3, 32'd3005);
    write_reg(REG_EXPECTED_FPS, 16'd1);
    write_reg(REG_NO_SKIP, 16'd1);
    for (int unsigned i = 0; i < 3; i++) send_frame(32'd4, 32'd4004 + i);
    write_reg(REG_NO_SKIP, 16'd0);
    write_reg(REG_EXPECTED_FPS, 16'd30);
  endtask

  task automatic test_backpressure();
    gap_pct = 0;
    stall_pct = 0;
    write_reg(REG_EXPECTED_FPS, 16'd8);
    hold_asked <= hold_asked + 1;
    run_stream(40, 12);
  endtask

  task automatic test_random_traffic();
    logic [15:0] fps;
    for (int unsigned p = 0; p < 4; p++) begin
      for (int unsigned s = 0; s < 2; s++) begin
        case (p)
          1: begin gap_pct = 54; stall_pct = 0; end
          2: begin gap_pct = 0; stall_pct = 54; end
          3: begin gap_pct = 28; stall_pct = 28; end
          default: begin gap_pct = 0; stall_pct = 0; end
        endcase
        case ($urandom_range(6))
          0: fps = 16'd0;
          1: fps = 16'd1;
          2: fps = 16'd2;
          3: fps = 16'd3;
          4: fps = 16'hFFFF;
          default: fps = 16'($urandom_range(25, 4));
        endcase
        write_reg(REG_EXPECTED_FPS, fps);
        write_reg(REG_NO_SKIP, 16'($urandom_range(3) == 0));
        run_stream(85, $urandom_range(30, 2));
      end
    end
  endtask

  task automatic test_long_second();
    logic [31:0] sec;
    logic [31:0] ms;
    gap_pct = 0;
    stall_pct = 0;
    write_reg(REG_EXPECTED_FPS, 16'hFFFF);
    write_reg(REG_NO_SKIP, 16'd1);
    sec = cur_sec + 32'd1;
    ms = $urandom();
    repeat (60) send_frame(sec, ms);
    write_reg(REG_NO_SKIP, 16'd0);
    write_reg(REG_EXPECTED_FPS, 16'd5);
    repeat (4) send_frame(sec, ms);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_config_extremes();
    test_backpressure();
    test_random_traffic();
    test_long_second();
    settle();
    repeat (120) @(posedge clk);
    $display("run covered %0d frames: %0d passed, %0d ratio drops, %0d quota drops",
             n_frames, n_passed, n_ratio, n_quota);
    $display("run covered %0d register writes, %0d cycles of input held off", n_writes, n_held);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
